// ===== rtl/core/htw_pkg.sv =====
// Shared types and constants for the hierarchical timer wheel.
package htw_pkg;

    localparam int LEVELS = 4;
    localparam int LVL_W = 2;
    localparam int LINK_W = 7;
    localparam logic [LINK_W-1:0] EMPTY_LINK = 7'd64;
    localparam int ID_FIELD_W = 6;

    typedef enum logic [1:0] {
        OUT_ONESHOT  = 2'd0,
        OUT_REARMED  = 2'd1,
        OUT_ARMED    = 2'd2,
        OUT_REJECTED = 2'd3
    } outcome_t;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_ARM  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        MODE_ARM,
        MODE_EXPIRE,
        MODE_CASCADE
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAKE_RD,
        ST_TAKE_WR,
        ST_TMR_RD,
        ST_TMR_USE,
        ST_PLACE_RD,
        ST_PLACE_WR,
        ST_ADVANCE
    } state_t;

    typedef struct packed {
        action_t                 action;
        logic [ID_FIELD_W-1:0]   timer_id;
        logic [31:0]             interval_ticks;
        logic                    repeat_mode;
    } request_t;

    typedef struct packed {
        logic [ID_FIELD_W-1:0]   fired_timer_id;
        outcome_t                outcome;
        logic                    last_of_run;
    } result_t;

    typedef struct packed {
        logic [LINK_W-1:0]       link;
        logic [63:0]             deadline;
        logic [31:0]             period;
        logic                    repeats;
    } timer_entry_t;

    typedef struct packed {
        logic                    link;
        logic                    deadline;
        logic                    period;
        logic                    repeats;
    } timer_wen_t;

endpackage

// ===== rtl/core/hierarchical_timer_wheel.sv =====
// Four-level timer wheel: sequencer over the slot head and timer memories.
// After reset the block is busy while the slot head memory is cleared. An arm writes
// the timer entry, then reads and rewrites a slot head; a rejected arm answers from
// idle. A tick takes the level-0 slot and walks its list, frees each expired one-shot
// timer and re-places each re-armed one; on a level-0 wrap it cascades the next level
// up, and further levels as their positions wrap. Each memory has a single read port:
// a re-placed timer reads its entry, then reads and rewrites a slot head. One result
// at most per cycle, shown for one cycle on result_valid; the receiver cannot stall it.
module hierarchical_timer_wheel #(
    parameter int WHEEL_BITS  = 8,
    parameter int POOL_TIMERS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  htw_pkg::request_t request,
    output logic              result_valid,
    output htw_pkg::result_t  result
);

    localparam int WB   = WHEEL_BITS;
    localparam int AW   = htw_pkg::LVL_W + WB;
    localparam int ID_W = (POOL_TIMERS > 1) ? $clog2(POOL_TIMERS) : 1;
    localparam int LW   = htw_pkg::LINK_W;
    localparam int ID_FIELD_W_MSB = htw_pkg::ID_FIELD_W - 1;

    htw_pkg::state_t      state_reg, state_next;
    htw_pkg::mode_t       mode_reg, mode_next;
    logic [1:0]           lvl_reg, lvl_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [LW-1:0]        place_id_reg, place_id_next;
    logic [63:0]          ticks_reg, ticks_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [WB-1:0]        pos_reg [htw_pkg::LEVELS];
    logic [WB-1:0]        pos_next [htw_pkg::LEVELS];
    logic [63:0]          tick_reg, tick_next;
    logic [POOL_TIMERS-1:0] tbusy_reg, tbusy_next;
    htw_pkg::result_t     result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    logic [AW-1:0]        head_raddr;
    logic [LW-1:0]        head_rdata;
    logic                 head_wen;
    logic [AW-1:0]        head_waddr;
    logic [LW-1:0]        head_wdata;
    logic                 head_ready;

    logic [ID_W-1:0]       tmr_raddr;
    htw_pkg::timer_entry_t tmr_rdata;
    htw_pkg::timer_wen_t   tmr_wen;
    logic [ID_W-1:0]       tmr_waddr;
    htw_pkg::timer_entry_t tmr_wdata;

    logic [1:0]           plvl;
    logic [WB-1:0]        poff;
    logic [AW-1:0]        place_idx;
    logic [31:0]          ival;
    logic                 arm_ok;
    logic [WB-1:0]        pos0_inc;

    htw_head_mem #(.AW(AW)) u_heads (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (head_raddr),
        .rd_data (head_rdata),
        .wr_en   (head_wen),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .ready   (head_ready)
    );

    htw_timer_mem #(.ID_W(ID_W)) u_timers (
        .clk     (clk),
        .rd_addr (tmr_raddr),
        .rd_data (tmr_rdata),
        .wr_en   (tmr_wen),
        .wr_addr (tmr_waddr),
        .wr_data (tmr_wdata)
    );

    assign busy         = (state_reg != htw_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if ((ticks_reg >> (3 * WB)) != '0)
        begin
            plvl = 2'd3;
        end
        else if ((ticks_reg >> (2 * WB)) != '0)
        begin
            plvl = 2'd2;
        end
        else if ((ticks_reg >> WB) != '0)
        begin
            plvl = 2'd1;
        end
        else
        begin
            plvl = 2'd0;
        end
        unique case (plvl)
            2'd0:    poff = ticks_reg[WB-1:0];
            2'd1:    poff = ticks_reg[2*WB-1:WB];
            2'd2:    poff = ticks_reg[3*WB-1:2*WB];
            default: poff = ticks_reg[4*WB-1:3*WB];
        endcase
        place_idx = {plvl, WB'(pos_reg[plvl] + poff)};
    end

    assign ival     = (request.interval_ticks == '0) ? 32'd1 : request.interval_ticks;
    assign arm_ok   = (({1'b0, request.timer_id}) < LW'(POOL_TIMERS))
                      && !tbusy_reg[request.timer_id[ID_W-1:0]];
    assign pos0_inc = pos_reg[0] + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        lvl_next          = lvl_reg;
        cur_next          = cur_reg;
        place_id_next     = place_id_reg;
        ticks_next        = ticks_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        tick_next         = tick_reg;
        tbusy_next        = tbusy_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        head_raddr = {lvl_reg, pos_reg[lvl_reg]};
        head_wen   = 1'b0;
        head_waddr = {lvl_reg, pos_reg[lvl_reg]};
        head_wdata = htw_pkg::EMPTY_LINK;

        tmr_raddr = cur_reg[ID_W-1:0];
        tmr_wen   = '0;
        tmr_waddr = cur_reg[ID_W-1:0];
        tmr_wdata.link     = head_rdata;
        tmr_wdata.deadline = tick_reg + 64'(tmr_rdata.period);
        tmr_wdata.period   = ival;
        tmr_wdata.repeats  = request.repeat_mode;

        unique case (state_reg)
            htw_pkg::ST_CLEAR:
            begin
                if (head_ready)
                begin
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            htw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (request.action == htw_pkg::ACT_ARM)
                    begin
                        result_next.fired_timer_id = request.timer_id;
                        result_next.last_of_run    = 1'b1;
                        if (arm_ok)
                        begin
                            tmr_waddr          = request.timer_id[ID_W-1:0];
                            tmr_wen.deadline   = 1'b1;
                            tmr_wen.period     = 1'b1;
                            tmr_wen.repeats    = 1'b1;
                            tmr_wdata.deadline = tick_reg + 64'(ival);
                            tbusy_next[request.timer_id[ID_W-1:0]] = 1'b1;
                            ticks_next    = 64'(ival);
                            place_id_next = {1'b0, request.timer_id};
                            mode_next     = htw_pkg::MODE_ARM;
                            state_next    = htw_pkg::ST_PLACE_RD;
                        end
                        else
                        begin
                            result_next.outcome = htw_pkg::OUT_REJECTED;
                            result_valid_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        lvl_next   = 2'd0;
                        mode_next  = htw_pkg::MODE_EXPIRE;
                        state_next = htw_pkg::ST_TAKE_RD;
                    end
                end
            end
            htw_pkg::ST_TAKE_RD:
            begin
                state_next = htw_pkg::ST_TAKE_WR;
            end
            htw_pkg::ST_TAKE_WR:
            begin
                head_wen = 1'b1;
                cur_next = head_rdata;
                state_next = htw_pkg::ST_TMR_RD;
                if (head_rdata[LW-1])
                begin
                    state_next = (mode_reg == htw_pkg::MODE_EXPIRE)
                                 ? htw_pkg::ST_ADVANCE : htw_pkg::ST_IDLE;
                    if (mode_reg == htw_pkg::MODE_CASCADE && pos_reg[lvl_reg] == '0
                        && lvl_reg != 2'd3)
                    begin
                        lvl_next = lvl_reg + 2'd1;
                        pos_next[lvl_reg + 2'd1] = pos_reg[lvl_reg + 2'd1] + 1'b1;
                        state_next = htw_pkg::ST_TAKE_RD;
                    end
                end
            end
            htw_pkg::ST_TMR_RD:
            begin
                state_next = htw_pkg::ST_TMR_USE;
            end
            htw_pkg::ST_TMR_USE:
            begin
                cur_next      = tmr_rdata.link;
                place_id_next = cur_reg;
                if (mode_reg == htw_pkg::MODE_EXPIRE)
                begin
                    result_valid_next          = 1'b1;
                    result_next.fired_timer_id = cur_reg[ID_FIELD_W_MSB:0];
                    result_next.last_of_run    = tmr_rdata.link[LW-1];
                    if (tmr_rdata.repeats)
                    begin
                        result_next.outcome = htw_pkg::OUT_REARMED;
                        tmr_wen.deadline    = 1'b1;
                        ticks_next          = 64'(tmr_rdata.period);
                        state_next          = htw_pkg::ST_PLACE_RD;
                    end
                    else
                    begin
                        result_next.outcome = htw_pkg::OUT_ONESHOT;
                        tbusy_next[cur_reg[ID_W-1:0]] = 1'b0;
                        state_next = tmr_rdata.link[LW-1]
                                     ? htw_pkg::ST_ADVANCE : htw_pkg::ST_TMR_RD;
                    end
                end
                else
                begin
                    ticks_next = tmr_rdata.deadline - tick_reg;
                    state_next = htw_pkg::ST_PLACE_RD;
                end
            end
            htw_pkg::ST_PLACE_RD:
            begin
                head_raddr = place_idx;
                idx_next   = place_idx;
                state_next = htw_pkg::ST_PLACE_WR;
            end
            htw_pkg::ST_PLACE_WR:
            begin
                tmr_waddr    = place_id_reg[ID_W-1:0];
                tmr_wen.link = 1'b1;
                head_wen     = 1'b1;
                head_waddr   = idx_reg;
                head_wdata   = place_id_reg;
                unique case (mode_reg)
                    htw_pkg::MODE_ARM:
                    begin
                        result_valid_next   = 1'b1;
                        result_next.outcome = htw_pkg::OUT_ARMED;
                        state_next          = htw_pkg::ST_IDLE;
                    end
                    htw_pkg::MODE_EXPIRE:
                    begin
                        state_next = cur_reg[LW-1] ? htw_pkg::ST_ADVANCE
                                                   : htw_pkg::ST_TMR_RD;
                    end
                    default:
                    begin
                        state_next = htw_pkg::ST_TMR_RD;
                        if (cur_reg[LW-1])
                        begin
                            state_next = htw_pkg::ST_IDLE;
                            if (pos_reg[lvl_reg] == '0 && lvl_reg != 2'd3)
                            begin
                                lvl_next = lvl_reg + 2'd1;
                                pos_next[lvl_reg + 2'd1] =
                                    pos_reg[lvl_reg + 2'd1] + 1'b1;
                                state_next = htw_pkg::ST_TAKE_RD;
                            end
                        end
                    end
                endcase
            end
            htw_pkg::ST_ADVANCE:
            begin
                pos_next[0] = pos0_inc;
                tick_next   = tick_reg + 64'd1;
                state_next  = htw_pkg::ST_IDLE;
                if (pos0_inc == '0)
                begin
                    lvl_next    = 2'd1;
                    pos_next[1] = pos_reg[1] + 1'b1;
                    mode_next   = htw_pkg::MODE_CASCADE;
                    state_next  = htw_pkg::ST_TAKE_RD;
                end
            end
            default:
            begin
                state_next = htw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= htw_pkg::ST_CLEAR;
            mode_reg         <= htw_pkg::MODE_ARM;
            lvl_reg          <= '0;
            cur_reg          <= htw_pkg::EMPTY_LINK;
            pos_reg          <= '{default: '0};
            tick_reg         <= '0;
            tbusy_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            lvl_reg          <= lvl_next;
            cur_reg          <= cur_next;
            pos_reg          <= pos_next;
            tick_reg         <= tick_next;
            tbusy_reg        <= tbusy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        place_id_reg <= place_id_next;
        ticks_reg    <= ticks_next;
        idx_reg      <= idx_next;
        result_reg   <= result_next;
    end

endmodule

// ===== rtl/core/htw_head_mem.sv =====
// Slot head memory with a clearing pass after reset.
module htw_head_mem #(
    parameter int AW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [AW-1:0]                 rd_addr,
    output logic [htw_pkg::LINK_W-1:0]    rd_data,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [htw_pkg::LINK_W-1:0]    wr_data,
    output logic                          ready
);

    logic [htw_pkg::LINK_W-1:0] mem [2**AW];
    logic [AW:0]                clr_cnt_reg;
    logic [AW:0]                clr_cnt_next;

    assign ready = clr_cnt_reg[AW];
    assign clr_cnt_next = ready ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ready)
        begin
            mem[clr_cnt_reg[AW-1:0]] <= htw_pkg::EMPTY_LINK;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/htw_timer_mem.sv =====
// Per-timer link, deadline, period and repeat memory.
module htw_timer_mem #(
    parameter int ID_W = 6
) (
    input  logic                   clk,
    input  logic [ID_W-1:0]        rd_addr,
    output htw_pkg::timer_entry_t  rd_data,
    input  htw_pkg::timer_wen_t    wr_en,
    input  logic [ID_W-1:0]        wr_addr,
    input  htw_pkg::timer_entry_t  wr_data
);

    logic [htw_pkg::LINK_W-1:0] link_mem     [2**ID_W];
    logic [63:0]                deadline_mem [2**ID_W];
    logic [31:0]                period_mem   [2**ID_W];
    logic                       repeat_mem   [2**ID_W];

    always_ff @(posedge clk)
    begin
        if (wr_en.link)
        begin
            link_mem[wr_addr] <= wr_data.link;
        end
        if (wr_en.deadline)
        begin
            deadline_mem[wr_addr] <= wr_data.deadline;
        end
        if (wr_en.period)
        begin
            period_mem[wr_addr] <= wr_data.period;
        end
        if (wr_en.repeats)
        begin
            repeat_mem[wr_addr] <= wr_data.repeats;
        end
        rd_data.link     <= link_mem[rd_addr];
        rd_data.deadline <= deadline_mem[rd_addr];
        rd_data.period   <= period_mem[rd_addr];
        rd_data.repeats  <= repeat_mem[rd_addr];
    end

endmodule

// ===== rtl/core/htw_checker.sv =====
// Port-level checks for the timer wheel, bound to the top level.
module htw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input htw_pkg::request_t request,
    input logic              result_valid,
    input htw_pkg::result_t  result
);

    a_arm_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.outcome == htw_pkg::OUT_ARMED
                         || result.outcome == htw_pkg::OUT_REJECTED)
        |-> result.last_of_run)
        else $error("arm result without last_of_run");

    a_transfer_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || result_valid)
        else $error("accepted transfer left no trace");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_run |=> busy)
        else $error("run ended without last_of_run");

    a_reject_prompt: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.outcome == htw_pkg::OUT_REJECTED
        |-> $past(start && !busy && request.action == htw_pkg::ACT_ARM))
        else $error("rejection not tied to an arm transfer");

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

// ===== tb/tb.sv =====
// Self-checking testbench for hierarchical_timer_wheel: queued driver, monitor, wheel predictor.
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS = 256;
    localparam int POOL = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        htw_pkg::request_t req;
        int                gap;
        bit                drain;
    } pending_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    htw_pkg::request_t request = '0;
    logic              busy;
    logic              result_valid;
    htw_pkg::result_t  result;

    pending_t         pend_q[$];
    htw_pkg::result_t fired_q[$];
    int       gap_left = 0;
    int       errors = 0;
    int       arms_sent = 0;
    int       ticks_sent = 0;
    int       results_seen = 0;
    int       idle_cycles = 0;

    logic [6:0]  heads [4*SLOTS];
    logic [6:0]  links [POOL];
    logic [63:0] due [POOL];
    logic [31:0] period [POOL];
    logic        repeats [POOL];
    logic        armed [POOL];
    logic [7:0]  pos [4];
    logic [63:0] ticks_now;

    hierarchical_timer_wheel dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void place_timer(int id);
        logic [63:0] span;
        logic [63:0] off;
        logic [7:0]  slot;
        int          lvl;
        span = due[id] - ticks_now;
        lvl = 0;
        while (lvl < 3 && (span >> (8 * (lvl + 1))) != 0)
            lvl++;
        off = span >> (8 * lvl);
        slot = pos[lvl] + off[7:0];
        links[id] = heads[lvl * SLOTS + slot];
        heads[lvl * SLOTS + slot] = id[6:0];
    endfunction

    function automatic int take_slot(int lvl);
        int h;
        h = heads[lvl * SLOTS + pos[lvl]];
        heads[lvl * SLOTS + pos[lvl]] = htw_pkg::EMPTY_LINK;
        return h;
    endfunction

    function automatic void wheel_step(htw_pkg::request_t rq);
        htw_pkg::result_t r;
        htw_pkg::result_t run[$];
        int      cur;
        int      nxt;
        int      n;
        int      lvl;
        if (rq.action == htw_pkg::ACT_ARM)
        begin
            r.fired_timer_id = rq.timer_id;
            r.outcome = htw_pkg::OUT_REJECTED;
            r.last_of_run = 1'b1;
            if (!armed[rq.timer_id])
            begin
                period[rq.timer_id] = (rq.interval_ticks == 0) ? 32'd1 : rq.interval_ticks;
                due[rq.timer_id] = ticks_now + period[rq.timer_id];
                repeats[rq.timer_id] = rq.repeat_mode;
                armed[rq.timer_id] = 1'b1;
                place_timer(rq.timer_id);
                r.outcome = htw_pkg::OUT_ARMED;
            end
            fired_q.push_back(r);
            return;
        end
        cur = take_slot(0);
        n = 0;
        while (cur < POOL && n < POOL)
        begin
            nxt = links[cur];
            r.fired_timer_id = cur[5:0];
            r.last_of_run = 1'b0;
            if (repeats[cur])
            begin
                due[cur] = ticks_now + period[cur];
                place_timer(cur);
                r.outcome = htw_pkg::OUT_REARMED;
            end
            else
            begin
                armed[cur] = 1'b0;
                r.outcome = htw_pkg::OUT_ONESHOT;
            end
            run.push_back(r);
            n++;
            cur = nxt;
        end
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
            fired_q.push_back(run[i]);
        pos[0] = pos[0] + 8'd1;
        ticks_now = ticks_now + 64'd1;
        if (pos[0] == 0)
        begin
            lvl = 1;
            while (lvl < 4)
            begin
                pos[lvl] = pos[lvl] + 8'd1;
                cur = take_slot(lvl);
                n = 0;
                while (cur < POOL && n < POOL)
                begin
                    nxt = links[cur];
                    place_timer(cur);
                    cur = nxt;
                    n++;
                end
                if (pos[lvl] != 0)
                    break;
                lvl++;
            end
        end
    endfunction

    function automatic void queue_item(htw_pkg::action_t act, int id, logic [31:0] ival,
                                       logic rep, int gap);
        pending_t p;
        p.req.action = act;
        p.req.timer_id = id[5:0];
        p.req.interval_ticks = ival;
        p.req.repeat_mode = rep;
        p.gap = gap;
        p.drain = 1'b0;
        pend_q.push_back(p);
    endfunction

    function automatic void queue_drain();
        pending_t p;
        p.req = '0;
        p.gap = 0;
        p.drain = 1'b1;
        pend_q.push_back(p);
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit holding;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            holding = start;
            if (start && !busy)
            begin
                wheel_step(request);
                if (request.action == htw_pkg::ACT_ARM)
                    arms_sent++;
                else
                    ticks_sent++;
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pend_q.size() > 0)
                begin
                    if (pend_q[0].drain)
                    begin
                        if (fired_q.size() == 0)
                            void'(pend_q.pop_front());
                    end
                    else
                    begin
                        request <= pend_q[0].req;
                        gap_left = pend_q[0].gap;
                        void'(pend_q.pop_front());
                        holding = 1'b1;
                    end
                end
            end
            start <= holding;
        end
    end

    always @(posedge clk)
    begin
        htw_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (fired_q.size() == 0)
            begin
                $display("%0t: unexpected result id=%0d outcome=%0d last=%0b", $time,
                         result.fired_timer_id, result.outcome, result.last_of_run);
                errors++;
            end
            else
            begin
                want = fired_q.pop_front();
                if (result.fired_timer_id !== want.fired_timer_id)
                begin
                    $display("%0t: timer id expected %0d actual %0d", $time,
                             want.fired_timer_id, result.fired_timer_id);
                    errors++;
                end
                if (result.outcome !== want.outcome)
                begin
                    $display("%0t: outcome expected %0d actual %0d", $time,
                             want.outcome, result.outcome);
                    errors++;
                end
                if (result.last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last flag expected %0b actual %0b", $time,
                             want.last_of_run, result.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        for (int i = 0; i < 4 * SLOTS; i++)
            heads[i] = htw_pkg::EMPTY_LINK;
        for (int i = 0; i < POOL; i++)
        begin
            links[i] = htw_pkg::EMPTY_LINK;
            armed[i] = 1'b0;
            repeats[i] = 1'b0;
            period[i] = '0;
            due[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            pos[i] = '0;
        ticks_now = '0;

        queue_item(htw_pkg::ACT_ARM, 0, 32'd1, 1'b0, 0);
        queue_item(htw_pkg::ACT_ARM, 0, 32'd5, 1'b1, 0);
        queue_item(htw_pkg::ACT_ARM, 1, 32'd0, 1'b1, 0);
        queue_item(htw_pkg::ACT_ARM, 2, 32'd1, 1'b0, 3);
        queue_item(htw_pkg::ACT_ARM, 3, 32'hFFFF_FFFF, 1'b0, 0);
        queue_item(htw_pkg::ACT_ARM, 4, 32'd256, 1'b0, 0);
        queue_item(htw_pkg::ACT_ARM, 5, 32'd65536, 1'b1, 0);
        queue_item(htw_pkg::ACT_ARM, 6, 32'd2, 1'b0, 0);
        queue_item(htw_pkg::ACT_TICK, 63, 32'hFFFF_FFFF, 1'b1, 0);
        queue_item(htw_pkg::ACT_TICK, 0, 32'd0, 1'b0, 5);
        queue_item(htw_pkg::ACT_TICK, 0, 32'd0, 1'b0, 0);
        queue_item(htw_pkg::ACT_ARM, 63, 32'd3, 1'b1, 0);
        queue_item(htw_pkg::ACT_ARM, 62, 32'd3, 1'b0, 0);
        queue_item(htw_pkg::ACT_ARM, 6, 32'd1, 1'b0, 0);
        for (int i = 0; i < 5; i++)
            queue_item(htw_pkg::ACT_TICK, 0, 32'd0, 1'b0, 0);
        queue_drain();

        for (int i = 0; i < 210; i++)
        begin
            if ($urandom_range(0, 99) < 78)
            begin
                queue_item(htw_pkg::ACT_TICK, $urandom_range(0, 63), $urandom,
                           $urandom_range(0, 1), draw_gap());
            end
            else
            begin
                r = $urandom_range(0, 9);
                queue_item(htw_pkg::ACT_ARM, $urandom_range(0, 63),
                           (r < 7) ? $urandom_range(0, 300) :
                           (r < 9) ? $urandom_range(0, 2000) : $urandom,
                           ($urandom_range(0, 3) == 0), draw_gap());
            end
            if (i % 70 == 69)
                queue_drain();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() > 0 || start || fired_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d arm and %0d tick transfers, checked %0d results.", arms_sent,
                 ticks_sent, results_seen);
        $display("Wheel reached tick %0d with busy, zero-interval and long-delay arms.",
                 ticks_now);
        if (errors == 0 && fired_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
